@@ design/etc_pkg.sv @@
`timescale 1ns / 1ps

package etc_pkg;

   // Limits of the settings and the countdown
   localparam int MAX_SECONDS   = 180;
   localparam int SECONDS_LIMIT = (MAX_SECONDS > 255) ? 255 : MAX_SECONDS;
   localparam int PERCENT_MAX   = 100;
   localparam int DUTY_FULL     = 65535;
   localparam int MS_PER_SEC    = 1000;
   localparam int REMAIN_MAX    = 262143;

   // Duty split: full scale over 100 as a whole part and a remainder part
   localparam int DUTY_WHOLE  = DUTY_FULL / PERCENT_MAX;
   localparam int DUTY_REST   = DUTY_FULL % PERCENT_MAX;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_100   = ((2 ** RECIP_SHIFT) + PERCENT_MAX - 1) / PERCENT_MAX;

   // Field widths
   localparam int POWER_W  = 7;
   localparam int SECS_W   = 8;
   localparam int REMAIN_W = 18;
   localparam int COUNT_W  = 16;
   localparam int DUTY_W   = 16;
   localparam int PROG_W   = 7;

   // Progress divider: remaining * 100 over total milliseconds, one quotient bit a cycle
   localparam int NUM_W     = REMAIN_W + 7;
   localparam int DIV_STEPS = NUM_W;
   localparam int DIVCNT_W  = $clog2(DIV_STEPS + 1);

   // Register map (byte address bit 2 selects the register)
   localparam logic REG_LONG_PRESS = 1'b0;
   localparam logic REG_DEBOUNCE   = 1'b1;
   localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET   = 16'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   // Screen codes
   localparam logic [1:0] SCREEN_MAIN  = 2'd0;
   localparam logic [1:0] SCREEN_POWER = 2'd1;
   localparam logic [1:0] SCREEN_TIME  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV
   } state_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_UP,
      STEP_DOWN
   } enc_step_type;

   typedef struct packed {
      logic [COUNT_W-1:0] long_press_ticks;
      logic [COUNT_W-1:0] debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic encoder_a;
      logic encoder_b;
      logic button1_level;
      logic button2_level;
   } req_type;

   typedef struct packed {
      logic                running;
      logic [DUTY_W-1:0]   pwm_duty;
      logic [1:0]          screen;
      logic                edit_active;
      logic [REMAIN_W-1:0] remaining_ms;
      logic [PROG_W-1:0]   progress_percent;
      logic [POWER_W-1:0]  power_setting;
      logic [SECS_W-1:0]   time_setting;
      logic                save_request;
      logic                finished;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic tick;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
   } status_type;

   // Decode one quadrature transition: previous {a,b} over current {a,b}
   function automatic enc_step_type quad_step(input logic [3:0] pair);
      enc_step_type dir;
      case (pair)
         4'h1, 4'h7, 4'hE, 4'h8: dir = STEP_UP;
         4'h2, 4'h4, 4'hD, 4'hB: dir = STEP_DOWN;
         default:                dir = STEP_NONE;
      endcase
      return dir;
   endfunction

   // Full exposure length in ms, saturated to the counter range
   function automatic logic [REMAIN_W-1:0] reload_ms(input logic [SECS_W-1:0] secs);
      logic [31:0] ms;
      ms = 32'(secs) * 32'(MS_PER_SEC);
      if (ms > 32'(REMAIN_MAX)) begin
         ms = 32'(REMAIN_MAX);
      end
      return ms[REMAIN_W-1:0];
   endfunction

   // Drive duty for a power percentage: power * whole part plus power * rest / 100,
   // the last quotient by reciprocal multiplication (exact for any 7-bit power)
   function automatic logic [DUTY_W-1:0] duty_of(input logic [POWER_W-1:0] power);
      logic [31:0] whole;
      logic [31:0] rest;
      whole = 32'(power) * 32'(DUTY_WHOLE);
      rest  = (32'(power) * 32'(DUTY_REST * RECIP_100)) >> RECIP_SHIFT;
      return DUTY_W'(whole + rest);
   endfunction

endpackage

@@ design/etc_if.sv @@
`timescale 1ns / 1ps

// Tick request channel
interface etc_req_if;
   logic valid;
   logic ready;
   logic encoder_a;
   logic encoder_b;
   logic button1_level;
   logic button2_level;

   modport source (output valid, encoder_a, encoder_b, button1_level, button2_level,
                   input ready);
   modport sink (input valid, encoder_a, encoder_b, button1_level, button2_level,
                 output ready);
endinterface

// Status response channel
interface etc_rsp_if;
   logic        valid;
   logic        ready;
   logic        running;
   logic [15:0] pwm_duty;
   logic [1:0]  screen;
   logic        edit_active;
   logic [17:0] remaining_ms;
   logic [6:0]  progress_percent;
   logic [6:0]  power_setting;
   logic [7:0]  time_setting;
   logic        save_request;
   logic        finished;

   modport source (output valid, running, pwm_duty, screen, edit_active, remaining_ms,
                   progress_percent, power_setting, time_setting, save_request,
                   finished,
                   input ready);
   modport sink (input valid, running, pwm_duty, screen, edit_active, remaining_ms,
                 progress_percent, power_setting, time_setting, save_request, finished,
                 output ready);
endinterface

@@ design/etc_csr.sv @@
`timescale 1ns / 1ps

module etc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output etc_pkg::cfg_type    cfg
);

   logic [etc_pkg::COUNT_W-1:0] long_press_ff;
   logic [etc_pkg::COUNT_W-1:0] debounce_ff;
   logic                        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Write the selected register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= etc_pkg::LONG_PRESS_RESET;
         debounce_ff   <= etc_pkg::DEBOUNCE_RESET;
      end else if (wr_en) begin
         if (paddr[2] == etc_pkg::REG_DEBOUNCE) begin
            debounce_ff <= pwdata[etc_pkg::COUNT_W-1:0];
         end else begin
            long_press_ff <= pwdata[etc_pkg::COUNT_W-1:0];
         end
      end
   end

   // Read back
   always_comb begin
      if (paddr[2] == etc_pkg::REG_LONG_PRESS) begin
         prdata = 32'(long_press_ff);
      end else begin
         prdata = 32'(debounce_ff);
      end
   end

   assign cfg.long_press_ticks = long_press_ff;
   assign cfg.debounce_ticks   = debounce_ff;

endmodule

@@ design/etc_ctrl.sv @@
`timescale 1ns / 1ps

module etc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  etc_pkg::status_type   status,
   output etc_pkg::cmd_type      cmd
);

   etc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence one request: apply the tick, load the divider, iterate, register the result
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         etc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.tick = 1'b1;
               state_in = etc_pkg::ST_LOAD;
            end
         end
         etc_pkg::ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = etc_pkg::ST_DIV;
         end
         etc_pkg::ST_DIV: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = etc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = etc_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the response until taken; a new load overrides the drop
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/etc_datapath.sv @@
`timescale 1ns / 1ps

module etc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  etc_pkg::cmd_type     cmd,
   output etc_pkg::status_type  status,
   input  etc_pkg::req_type     req_data,
   input  etc_pkg::cfg_type     cfg,
   output etc_pkg::rsp_type     rsp_data
);

   localparam int RW = etc_pkg::REMAIN_W;
   localparam int NW = etc_pkg::NUM_W;

   // Controller state of the timer
   logic [1:0]                  screen_ff, screen_in;
   logic                        edit_ff, edit_in;
   logic [etc_pkg::POWER_W-1:0] power_ff, power_in;
   logic [etc_pkg::SECS_W-1:0]  seconds_ff, seconds_in;
   logic [RW-1:0]               remain_ff, remain_in;
   logic                        run_ff, run_in;
   logic [1:0]                  quad_ff, quad_in;
   logic [1:0]                  prev_ff, prev_in;
   logic [1:0]                  pressed_ff, pressed_in;
   logic [1:0]                  handled_ff, handled_in;
   logic [1:0]                  pending_ff, pending_in;
   logic [etc_pkg::COUNT_W-1:0] press_cnt_ff [2];
   logic [etc_pkg::COUNT_W-1:0] press_cnt_in [2];
   logic                        save_ff, save_in;
   logic                        done_ff, done_in;

   // Progress divider
   logic [NW-1:0]                num_ff;
   logic [RW-1:0]                den_ff;
   logic [RW-1:0]                part_ff, part_in;
   logic [etc_pkg::DIVCNT_W-1:0] div_cnt_ff;
   logic [RW:0]                  part_shift;
   logic                         quo_bit;
   logic [etc_pkg::PROG_W-1:0]   progress;

   logic [1:0]                  levels;
   logic [etc_pkg::COUNT_W-1:0] n0, n1;

   etc_pkg::rsp_type rsp_ff;

   assign levels = {req_data.button2_level, req_data.button1_level};

   // Advance the timer by one tick: countdown, encoder, then buttons
   always_comb begin
      screen_in       = screen_ff;
      edit_in         = edit_ff;
      power_in        = power_ff;
      seconds_in      = seconds_ff;
      remain_in       = remain_ff;
      run_in          = run_ff;
      prev_in         = prev_ff;
      pressed_in      = pressed_ff;
      handled_in      = handled_ff;
      pending_in      = pending_ff;
      press_cnt_in[0] = press_cnt_ff[0];
      press_cnt_in[1] = press_cnt_ff[1];
      save_in         = 1'b0;
      done_in         = 1'b0;
      quad_in         = {req_data.encoder_a, req_data.encoder_b};

      // Count down on the main screen; at the last millisecond end and reload
      if (run_in && screen_in == etc_pkg::SCREEN_MAIN) begin
         if (remain_in > RW'(1)) begin
            remain_in = remain_in - RW'(1);
         end else begin
            run_in    = 1'b0;
            remain_in = etc_pkg::reload_ms(seconds_in);
            done_in   = 1'b1;
         end
      end

      // Adjust the shown setting in edit mode
      if (edit_in) begin
         case (etc_pkg::quad_step({quad_ff, quad_in}))
            etc_pkg::STEP_UP: begin
               if (screen_in == etc_pkg::SCREEN_POWER) begin
                  if (power_in < etc_pkg::POWER_W'(etc_pkg::PERCENT_MAX)) begin
                     power_in = power_in + etc_pkg::POWER_W'(1);
                  end
               end else if (screen_in == etc_pkg::SCREEN_TIME) begin
                  if (seconds_in < etc_pkg::SECS_W'(etc_pkg::SECONDS_LIMIT)) begin
                     seconds_in = seconds_in + etc_pkg::SECS_W'(1);
                  end
               end
            end
            etc_pkg::STEP_DOWN: begin
               if (screen_in == etc_pkg::SCREEN_POWER) begin
                  if (power_in != '0) begin
                     power_in = power_in - etc_pkg::POWER_W'(1);
                  end
               end else if (screen_in == etc_pkg::SCREEN_TIME) begin
                  if (seconds_in != '0) begin
                     seconds_in = seconds_in - etc_pkg::SECS_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // Track press edges and press length of both buttons
      for (int i = 0; i < 2; i++) begin
         if (prev_ff[i] && !levels[i]) begin
            pressed_in[i]   = 1'b1;
            handled_in[i]   = 1'b0;
            pending_in[i]   = 1'b1;
            press_cnt_in[i] = '0;
         end else begin
            if (!prev_ff[i] && levels[i]) begin
               pressed_in[i] = 1'b0;
            end
            if (pending_in[i] && press_cnt_in[i] != etc_pkg::COUNT_MAX) begin
               press_cnt_in[i] = press_cnt_in[i] + etc_pkg::COUNT_W'(1);
            end
         end
      end
      prev_in = levels;
      n0      = press_cnt_in[0];
      n1      = press_cnt_in[1];

      // Screen/edit button: long toggles edit on the setting screens, short release cycles screens
      if (pressed_in[0] && !handled_in[0]) begin
         if (n0 >= cfg.long_press_ticks) begin
            handled_in[0] = 1'b1;
            if (screen_in == etc_pkg::SCREEN_POWER || screen_in == etc_pkg::SCREEN_TIME) begin
               edit_in = !edit_in;
               if (!edit_in) begin
                  save_in = 1'b1;
               end
            end
         end
      end else if (!pressed_in[0] && pending_in[0]) begin
         if (n0 < cfg.long_press_ticks && n0 > cfg.debounce_ticks && !edit_in && !run_in)
         begin
            if (screen_in >= etc_pkg::SCREEN_TIME) begin
               screen_in = etc_pkg::SCREEN_MAIN;
            end else begin
               screen_in = screen_in + 2'd1;
            end
            if (screen_in == etc_pkg::SCREEN_MAIN) begin
               run_in    = 1'b0;
               remain_in = etc_pkg::reload_ms(seconds_in);
            end else begin
               save_in = 1'b1;
            end
         end
         pending_in[0] = 1'b0;
         handled_in[0] = 1'b0;
      end

      // Start/pause button on the main screen: long resets, short release starts or pauses
      if (pressed_in[1] && !handled_in[1]) begin
         if (n1 >= cfg.long_press_ticks) begin
            handled_in[1] = 1'b1;
            if (screen_in == etc_pkg::SCREEN_MAIN) begin
               run_in    = 1'b0;
               remain_in = etc_pkg::reload_ms(seconds_in);
            end
         end
      end else if (!pressed_in[1] && pending_in[1]) begin
         if (n1 < cfg.long_press_ticks && n1 > cfg.debounce_ticks &&
             screen_in == etc_pkg::SCREEN_MAIN && !handled_in[1]) begin
            if (run_in) begin
               run_in = 1'b0;
            end else if (remain_in != '0) begin
               run_in = 1'b1;
            end
         end
         pending_in[1] = 1'b0;
         handled_in[1] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff       <= etc_pkg::SCREEN_MAIN;
         edit_ff         <= 1'b0;
         power_ff        <= '0;
         seconds_ff      <= '0;
         remain_ff       <= '0;
         run_ff          <= 1'b0;
         quad_ff         <= 2'b11;
         prev_ff         <= 2'b11;
         pressed_ff      <= '0;
         handled_ff      <= '0;
         pending_ff      <= '0;
         press_cnt_ff[0] <= '0;
         press_cnt_ff[1] <= '0;
         save_ff         <= 1'b0;
         done_ff         <= 1'b0;
      end else if (cmd.tick) begin
         screen_ff       <= screen_in;
         edit_ff         <= edit_in;
         power_ff        <= power_in;
         seconds_ff      <= seconds_in;
         remain_ff       <= remain_in;
         run_ff          <= run_in;
         quad_ff         <= quad_in;
         prev_ff         <= prev_in;
         pressed_ff      <= pressed_in;
         handled_ff      <= handled_in;
         pending_ff      <= pending_in;
         press_cnt_ff[0] <= press_cnt_in[0];
         press_cnt_ff[1] <= press_cnt_in[1];
         save_ff         <= save_in;
         done_ff         <= done_in;
      end
   end

   // Restoring divider step: shift in one numerator bit, subtract when it fits
   always_comb begin
      part_shift = {part_ff, num_ff[NW-1]};
      quo_bit    = (part_shift >= {1'b0, den_ff});
      if (quo_bit) begin
         part_in = RW'(part_shift - {1'b0, den_ff});
      end else begin
         part_in = RW'(part_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff  <= NW'(remain_ff) * NW'(etc_pkg::PERCENT_MAX);
         den_ff  <= etc_pkg::reload_ms(seconds_ff);
         part_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff  <= {num_ff[NW-2:0], quo_bit};
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_load) begin
         div_cnt_ff <= etc_pkg::DIVCNT_W'(etc_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - etc_pkg::DIVCNT_W'(1);
      end
   end

   assign status.div_done = (div_cnt_ff == '0);

   // Clamp the quotient; no total means no progress
   always_comb begin
      if (seconds_ff == '0) begin
         progress = '0;
      end else if (num_ff > NW'(etc_pkg::PERCENT_MAX)) begin
         progress = etc_pkg::PROG_W'(etc_pkg::PERCENT_MAX);
      end else begin
         progress = num_ff[etc_pkg::PROG_W-1:0];
      end
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.running          <= run_ff;
         rsp_ff.pwm_duty         <= run_ff ? etc_pkg::duty_of(power_ff) : '0;
         rsp_ff.screen           <= screen_ff;
         rsp_ff.edit_active      <= edit_ff;
         rsp_ff.remaining_ms     <= remain_ff;
         rsp_ff.progress_percent <= progress;
         rsp_ff.power_setting    <= power_ff;
         rsp_ff.time_setting     <= seconds_ff;
         rsp_ff.save_request     <= save_ff;
         rsp_ff.finished         <= done_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ design/exposure_timer_controller.sv @@
`timescale 1ns / 1ps

// Exposure timer controller. Each request is one 1 ms tick carrying the sampled encoder
// levels and two active-low button levels; each request yields exactly one response with
// the drive duty, screen, edit flag, remaining time, progress and settings, plus one-tick
// save and finished pulses. A request is taken only while the block is idle: the
// accepting cycle applies the tick, then the progress divider is loaded, the restoring
// divider runs (one quotient bit per cycle), and the response is registered; req ready
// returns after that. The next request is accepted while a response still waits in the
// output register; only a response still unclaimed when the following one finishes
// stalls the block. Registers: long_press_ticks at byte address 0, debounce_ticks at 4;
// the user must write them only while the block is idle, which the block does not enforce.

module exposure_timer_controller (
   input  logic         clock,
   input  logic         reset,
   etc_req_if.sink      req_ch,
   etc_rsp_if.source    rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   etc_pkg::cfg_type    cfg;
   etc_pkg::cmd_type    cmd;
   etc_pkg::status_type status;
   etc_pkg::req_type    req_data;
   etc_pkg::rsp_type    rsp_data;

   assign req_data.encoder_a     = req_ch.encoder_a;
   assign req_data.encoder_b     = req_ch.encoder_b;
   assign req_data.button1_level = req_ch.button1_level;
   assign req_data.button2_level = req_ch.button2_level;

   etc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   etc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   etc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .cfg      (cfg),
      .rsp_data (rsp_data)
   );

   assign rsp_ch.running          = rsp_data.running;
   assign rsp_ch.pwm_duty         = rsp_data.pwm_duty;
   assign rsp_ch.screen           = rsp_data.screen;
   assign rsp_ch.edit_active      = rsp_data.edit_active;
   assign rsp_ch.remaining_ms     = rsp_data.remaining_ms;
   assign rsp_ch.progress_percent = rsp_data.progress_percent;
   assign rsp_ch.power_setting    = rsp_data.power_setting;
   assign rsp_ch.time_setting     = rsp_data.time_setting;
   assign rsp_ch.save_request     = rsp_data.save_request;
   assign rsp_ch.finished         = rsp_data.finished;

endmodule

@@ design/etc_checker.sv @@
`timescale 1ns / 1ps

module etc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_running,
   input logic [15:0] rsp_pwm_duty,
   input logic [1:0]  rsp_screen,
   input logic        rsp_edit_active,
   input logic [6:0]  rsp_progress_percent,
   input logic        rsp_finished
);

   // A response stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // No drive while the countdown is stopped
   a_duty_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running |-> rsp_pwm_duty == '0)
      else $error("drive duty nonzero while not running");

   // The countdown only ends outside edit mode
   a_finish_edit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_edit_active)
      else $error("finished pulse in edit mode");

   // Progress is clamped
   a_prog_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_progress_percent <= 7'(etc_pkg::PERCENT_MAX))
      else $error("progress above full scale");

   // Edit mode exists only on the setting screens
   a_edit_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edit_active |-> rsp_screen != etc_pkg::SCREEN_MAIN)
      else $error("edit mode on the main screen");

endmodule

bind exposure_timer_controller etc_checker u_etc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_running          (rsp_ch.running),
   .rsp_pwm_duty         (rsp_ch.pwm_duty),
   .rsp_screen           (rsp_ch.screen),
   .rsp_edit_active      (rsp_ch.edit_active),
   .rsp_progress_percent (rsp_ch.progress_percent),
   .rsp_finished         (rsp_ch.finished)
);
